// ===== rtl/plane_sphere_intersection_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; take in with `include.
`ifndef PLANE_SPHERE_INTERSECTION_MACROS_SVH
`define PLANE_SPHERE_INTERSECTION_MACROS_SVH

// Property under clock and active-low reset.
`define PSI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Signal holds in the cycle after cond.
`define PSI_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("assertion failed");

`endif

// ===== rtl/psi_pkg.sv =====
// Types and constants of the plane/sphere intersection block.
// Depends on nothing.
package psi_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int SAT_BITS = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);
    localparam int SQRT_STEPS = 31;
    localparam logic [30:0] TOL_RESET = 31'd66;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_POINT  = 2'd1,
        KIND_CIRCLE = 2'd2
    } psi_kind_t;

    typedef struct packed {
        logic signed [31:0] plane_point_x;
        logic signed [31:0] plane_point_y;
        logic signed [31:0] plane_point_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] sphere_center_x;
        logic signed [31:0] sphere_center_y;
        logic signed [31:0] sphere_center_z;
        logic [30:0]        sphere_radius;
    } psi_item_t;

    typedef struct packed {
        psi_kind_t          kind;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic [30:0]        circle_radius;
    } psi_res_t;

    // Front end to square root pipeline.
    typedef struct packed {
        logic        valid;
        psi_kind_t   kind;
        logic [2:0][31:0] center;
        logic [2:0][31:0] axis;
        logic [61:0] radicand;
    } psi_mid_t;

endpackage

// ===== rtl/psi_ifs.sv =====
// Channel interfaces: input items, results, tolerance writes.
// Depends on psi_pkg.
interface psi_in_if import psi_pkg::*;;
    logic      valid;
    logic      ready;
    psi_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface psi_out_if import psi_pkg::*;;
    logic     valid;
    logic     ready;
    psi_res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface psi_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/plane_sphere_intersection.sv =====
// Pipeline: 38 register stages from the input transfer to the result register.
// Throughput: one item per cycle while the result is not stalled; the 31-stage root
// pipeline and the distance multipliers each take a new item every cycle.
// A stalled result freezes all stages together, bubbles included.
// Reset clears all valid bits and sets the tolerance to 66.
module plane_sphere_intersection
    import psi_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    psi_in_if.sink    item,
    psi_out_if.source result,
    psi_cfg_if.sink   cfg
);

    logic        adv;
    logic [30:0] tol_reg;
    psi_mid_t    mid;
    logic        res_valid;
    psi_res_t    res;

    assign adv = !res_valid || result.ready;
    assign item.ready = adv;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg.valid)
        begin
            tol_reg <= cfg.data;
        end
    end

    psi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (item.valid),
        .in_item  (item.data),
        .tol      (tol_reg),
        .mid      (mid)
    );

    psi_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .mid       (mid),
        .res_valid (res_valid),
        .res       (res)
    );

    assign result.valid = res_valid;
    assign result.data = res;

endmodule

// ===== rtl/psi_front.sv =====
// Distance, classification, foot point and radicand stages.
// Depends on psi_pkg.
module psi_front
    import psi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_valid,
    input  psi_item_t in_item,
    input  logic [30:0] tol,
    output psi_mid_t  mid
);

    logic [5:0] valid_reg;

    logic signed [32:0] diff_reg [3];
    logic signed [31:0] nrm1_reg [3];
    logic signed [31:0] ctr1_reg [3];
    logic [30:0]        r1_reg;

    logic signed [64:0] p_reg [3];
    logic signed [31:0] nrm2_reg [3];
    logic signed [31:0] ctr2_reg [3];
    logic [30:0]        r2_reg;

    logic signed [36:0] d_reg;
    logic signed [31:0] nrm3_reg [3];
    logic signed [31:0] ctr3_reg [3];
    logic [30:0]        r3_reg;

    psi_kind_t          kind4_reg;
    logic signed [32:0] d4_reg;
    logic [31:0]        absd4_reg;
    logic signed [31:0] nrm4_reg [3];
    logic signed [31:0] ctr4_reg [3];
    logic [30:0]        r4_reg;

    psi_kind_t          kind5_reg;
    logic signed [64:0] off5_reg [3];
    logic signed [31:0] nrm5_reg [3];
    logic signed [31:0] ctr5_reg [3];
    logic [61:0]        rr5_reg;
    logic [63:0]        dd5_reg;

    psi_mid_t mid_reg;
    psi_mid_t mid_next;

    logic signed [66:0] sum_p;
    logic signed [36:0] d_next;
    logic signed [37:0] absd;
    psi_kind_t          kind_next;
    logic signed [37:0] hi_lim;
    logic signed [37:0] lo_lim;

    localparam logic signed [35:0] SAT_HI = (36'sd1 <<< (SAT_BITS - 1)) - 36'sd1;
    localparam logic signed [35:0] SAT_LO = -SAT_HI - 36'sd1;

    always_comb
    begin
        sum_p = 67'(p_reg[0]) + 67'(p_reg[1]) + 67'(p_reg[2]) + 67'sd536870912;
        d_next = sum_p[66:30];
        absd = d_reg[36] ? -38'(d_reg) : 38'(d_reg);
        hi_lim = 38'($signed({1'b0, r3_reg})) + 38'($signed({1'b0, tol}));
        lo_lim = 38'($signed({1'b0, r3_reg})) - 38'($signed({1'b0, tol}));
        if (absd > hi_lim)
        begin
            kind_next = KIND_NONE;
        end
        else if (absd > lo_lim)
        begin
            kind_next = KIND_POINT;
        end
        else
        begin
            kind_next = KIND_CIRCLE;
        end
    end

    always_comb
    begin
        logic signed [64:0] rnd;
        logic signed [35:0] sum;
        mid_next.valid = valid_reg[4];
        mid_next.kind = kind5_reg;
        mid_next.radicand = 62'(64'(rr5_reg) - dd5_reg);
        for (int i = 0; i < 3; i++)
        begin
            rnd = off5_reg[i] + 65'sd536870912;
            sum = 36'(ctr5_reg[i]) + 36'($signed(rnd[64:30]));
            if (kind5_reg == KIND_NONE)
            begin
                mid_next.center[i] = '0;
            end
            else if (sum > SAT_HI)
            begin
                mid_next.center[i] = SAT_HI[31:0];
            end
            else if (sum < SAT_LO)
            begin
                mid_next.center[i] = SAT_LO[31:0];
            end
            else
            begin
                mid_next.center[i] = sum[31:0];
            end
            if (kind5_reg != KIND_CIRCLE)
            begin
                mid_next.axis[i] = '0;
            end
            else if (nrm5_reg[i] == 32'sh8000_0000)
            begin
                mid_next.axis[i] = 32'h7FFF_FFFF;
            end
            else
            begin
                mid_next.axis[i] = -nrm5_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_reg[0] <= 33'(in_item.plane_point_x) - 33'(in_item.sphere_center_x);
            diff_reg[1] <= 33'(in_item.plane_point_y) - 33'(in_item.sphere_center_y);
            diff_reg[2] <= 33'(in_item.plane_point_z) - 33'(in_item.sphere_center_z);
            nrm1_reg[0] <= in_item.normal_x;
            nrm1_reg[1] <= in_item.normal_y;
            nrm1_reg[2] <= in_item.normal_z;
            ctr1_reg[0] <= in_item.sphere_center_x;
            ctr1_reg[1] <= in_item.sphere_center_y;
            ctr1_reg[2] <= in_item.sphere_center_z;
            r1_reg <= in_item.sphere_radius;

            for (int i = 0; i < 3; i++)
            begin
                p_reg[i] <= 65'(diff_reg[i]) * 65'(nrm1_reg[i]);
            end
            nrm2_reg <= nrm1_reg;
            ctr2_reg <= ctr1_reg;
            r2_reg <= r1_reg;

            d_reg <= d_next;
            nrm3_reg <= nrm2_reg;
            ctr3_reg <= ctr2_reg;
            r3_reg <= r2_reg;

            kind4_reg <= kind_next;
            d4_reg <= d_reg[32:0];
            absd4_reg <= absd[31:0];
            nrm4_reg <= nrm3_reg;
            ctr4_reg <= ctr3_reg;
            r4_reg <= r3_reg;

            kind5_reg <= kind4_reg;
            for (int i = 0; i < 3; i++)
            begin
                off5_reg[i] <= 65'(d4_reg) * 65'(nrm4_reg[i]);
            end
            nrm5_reg <= nrm4_reg;
            ctr5_reg <= ctr4_reg;
            rr5_reg <= 62'(r4_reg) * 62'(r4_reg);
            dd5_reg <= 64'(absd4_reg) * 64'(absd4_reg);

            mid_reg <= mid_next;
        end
    end

    always_comb
    begin
        mid = mid_reg;
        mid.valid = valid_reg[5];
    end

endmodule

// ===== rtl/psi_sqrt.sv =====
// Bit-per-stage square root of the radicand with round to nearest.
// Depends on psi_pkg.
module psi_sqrt
    import psi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  psi_mid_t mid,
    output logic     res_valid,
    output psi_res_t res
);

    logic [SQRT_STEPS-1:0] valid_reg;
    psi_mid_t    data_reg [SQRT_STEPS];
    logic [30:0] root_reg [SQRT_STEPS];
    logic [32:0] rem_reg  [SQRT_STEPS];

    logic [30:0] root_next [SQRT_STEPS];
    logic [32:0] rem_next  [SQRT_STEPS];

    logic     out_valid_reg;
    psi_res_t out_reg;
    psi_res_t out_next;

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_step
        logic [30:0] root_in;
        logic [32:0] rem_in;
        logic [61:0] rad_in;
        logic [34:0] rem_t;
        logic [34:0] trial;

        if (j == 0)
        begin : g_first
            assign root_in = '0;
            assign rem_in  = '0;
            assign rad_in  = mid.radicand;
        end
        else
        begin : g_rest
            assign root_in = root_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign rad_in  = data_reg[j-1].radicand;
        end

        always_comb
        begin
            rem_t = {rem_in, rad_in[61-2*j -: 2]};
            trial = {2'b00, root_in, 2'b01};
            if (rem_t >= trial)
            begin
                rem_next[j] = 33'(rem_t - trial);
                root_next[j] = {root_in[29:0], 1'b1};
            end
            else
            begin
                rem_next[j] = rem_t[32:0];
                root_next[j] = {root_in[29:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                root_reg[j] <= root_next[j];
                rem_reg[j] <= rem_next[j];
                if (j == 0)
                begin
                    data_reg[j] <= mid;
                end
                else
                begin
                    data_reg[j] <= data_reg[j-1];
                end
            end
        end
    end

    always_comb
    begin
        logic [30:0] root;
        root = root_reg[SQRT_STEPS-1];
        out_next.kind = data_reg[SQRT_STEPS-1].kind;
        out_next.center_x = data_reg[SQRT_STEPS-1].center[0];
        out_next.center_y = data_reg[SQRT_STEPS-1].center[1];
        out_next.center_z = data_reg[SQRT_STEPS-1].center[2];
        out_next.axis_x = data_reg[SQRT_STEPS-1].axis[0];
        out_next.axis_y = data_reg[SQRT_STEPS-1].axis[1];
        out_next.axis_z = data_reg[SQRT_STEPS-1].axis[2];
        if (data_reg[SQRT_STEPS-1].kind != KIND_CIRCLE)
        begin
            out_next.circle_radius = '0;
        end
        else if (rem_reg[SQRT_STEPS-1] > 33'(root))
        begin
            out_next.circle_radius = root + 31'd1;
        end
        else
        begin
            out_next.circle_radius = root;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[SQRT_STEPS-2:0], mid.valid};
            out_valid_reg <= valid_reg[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res = out_reg;

endmodule

// ===== rtl/psi_checker.sv =====
// Port-level checks of the intersection block, bound to the top level.
// Depends on psi_pkg and plane_sphere_intersection_macros.svh.
`include "plane_sphere_intersection_macros.svh"

module psi_checker
    import psi_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     out_valid,
    input logic     out_ready,
    input logic     in_ready,
    input psi_res_t out_data
);

    `PSI_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid && !out_ready, out_data)
    `PSI_ASSERT(a_kind_code, clk, rst_n, out_valid |-> (out_data.kind != 2'd3))
    `PSI_ASSERT(a_none_zero, clk, rst_n, (out_valid && out_data.kind == KIND_NONE) |-> (out_data.center_x == 0 && out_data.center_y == 0 && out_data.center_z == 0))
    `PSI_ASSERT(a_axis_zero, clk, rst_n, (out_valid && out_data.kind != KIND_CIRCLE) |-> (out_data.axis_x == 0 && out_data.axis_y == 0 && out_data.axis_z == 0 && out_data.circle_radius == 0))
    `PSI_ASSERT(a_stall_ready, clk, rst_n, (out_valid && !out_ready) |-> !in_ready)

endmodule

bind plane_sphere_intersection psi_checker u_psi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .in_ready  (item.ready),
    .out_data  (result.data)
);
